// ===== rtl/tcgec_pkg.sv =====
package tcgec_pkg;

    localparam int unsigned TICKS_PER_STEP_DEF  = 25;
    localparam int unsigned STEPS_PER_TENTH_DEF = 5;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned WINDOW_W = 2;
    localparam int unsigned EVENTS_W = 6;
    localparam int unsigned TENTHS_W = 4;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned COUNT_W  = 16;

    localparam int unsigned TENTHS_PER_SEC = 10;
    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned MINS_PER_HOUR  = 60;

    // event bit positions
    localparam int unsigned EV_TICK   = 0;
    localparam int unsigned EV_20MS   = 1;
    localparam int unsigned EV_100MS  = 2;
    localparam int unsigned EV_SECOND = 3;
    localparam int unsigned EV_MINUTE = 4;
    localparam int unsigned EV_HOUR   = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 3'd0,
        MODE_EDGE      = 3'd1,
        MODE_SET_MIN   = 3'd2,
        MODE_SET_SEC   = 3'd3,
        MODE_START     = 3'd4,
        MODE_NOTIFY    = 3'd5,
        MODE_STOP      = 3'd6
    } t_mode;

    typedef enum logic [WINDOW_W-1:0] {
        WIN_SECOND = 2'd0,
        WIN_TICK   = 2'd1,
        WIN_20MS   = 2'd2,
        WIN_OPEN   = 2'd3
    } t_window;

    typedef enum logic [5:0] {
        EM_IDLE   = 6'b000001,
        EM_SECOND = 6'b000010,
        EM_TICK   = 6'b000100,
        EM_20MS   = 6'b001000,
        EM_NOTIFY = 6'b010000,
        EM_OPEN   = 6'b100000
    } t_edge_mode;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VALUE_W-1:0]  value;
        logic [WINDOW_W-1:0] window;
    } t_item;

    typedef struct packed {
        logic [EVENTS_W-1:0] events;
        logic [TENTHS_W-1:0] tenths;
        logic [SEC_W-1:0]    seconds_now;
        logic [MIN_W-1:0]    minutes_now;
        logic [COUNT_W-1:0]  edge_count;
        logic                counting;
        logic                ping;
    } t_result;

endpackage

// ===== rtl/tcgec_in_if.sv =====
interface tcgec_in_if;
    import tcgec_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [VALUE_W-1:0]  value;
    logic [WINDOW_W-1:0] window;

    modport source (output valid, output mode, output value, output window, input ready);
    modport sink   (input valid, input mode, input value, input window, output ready);
endinterface

// ===== rtl/tcgec_out_if.sv =====
interface tcgec_out_if;
    import tcgec_pkg::*;

    logic                valid;
    logic                ready;
    logic [EVENTS_W-1:0] events;
    logic [TENTHS_W-1:0] tenths;
    logic [SEC_W-1:0]    seconds_now;
    logic [MIN_W-1:0]    minutes_now;
    logic [COUNT_W-1:0]  edge_count;
    logic                counting;
    logic                ping;

    modport source (
        output valid, output events, output tenths, output seconds_now,
        output minutes_now, output edge_count, output counting, output ping,
        input ready
    );
    modport sink (
        input valid, input events, input tenths, input seconds_now,
        input minutes_now, input edge_count, input counting, input ping,
        output ready
    );
endinterface

// ===== rtl/tcgec_core.sv =====
module tcgec_core #(
    parameter int unsigned TICKS_PER_STEP  = tcgec_pkg::TICKS_PER_STEP_DEF,
    parameter int unsigned STEPS_PER_TENTH = tcgec_pkg::STEPS_PER_TENTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tcgec_pkg::t_item   i_item,
    output tcgec_pkg::t_result o_res
);
    import tcgec_pkg::*;

    localparam int unsigned SUB_W  = $clog2(TICKS_PER_STEP);
    localparam int unsigned STEP_W = $clog2(STEPS_PER_TENTH);
    localparam logic [SUB_W-1:0]    SUB_LAST   = SUB_W'(TICKS_PER_STEP - 1);
    localparam logic [STEP_W-1:0]   STEP_LAST  = STEP_W'(STEPS_PER_TENTH - 1);
    localparam logic [TENTHS_W-1:0] TENTH_LAST = TENTHS_W'(TENTHS_PER_SEC - 1);
    localparam logic [SEC_W-1:0]    SEC_LAST   = SEC_W'(SECS_PER_MIN - 1);
    localparam logic [MIN_W-1:0]    MIN_LAST   = MIN_W'(MINS_PER_HOUR - 1);
    localparam logic [VALUE_W-1:0]  SET_LIMIT  = VALUE_W'(SECS_PER_MIN);

    logic [SUB_W-1:0]    r_subtick, n_subtick;
    logic [STEP_W-1:0]   r_step,    n_step;
    logic [TENTHS_W-1:0] r_tenth,   n_tenth;
    logic [SEC_W-1:0]    r_sec,     n_sec;
    logic [MIN_W-1:0]    r_min,     n_min;
    t_edge_mode          r_emode,   n_emode;
    logic [COUNT_W-1:0]  r_total,   n_total;
    logic [EVENTS_W-1:0] w_events;
    logic                w_ping;
    logic                w_open_now;

    assign w_open_now = r_emode inside {EM_SECOND, EM_TICK, EM_20MS, EM_OPEN};

    always_comb begin
        n_subtick = r_subtick;
        n_step    = r_step;
        n_tenth   = r_tenth;
        n_sec     = r_sec;
        n_min     = r_min;
        n_emode   = r_emode;
        n_total   = r_total;
        w_events  = '0;
        w_ping    = 1'b0;
        case (i_item.mode)
            MODE_TICK: begin
                // cascade: each stage rolls only when the one below wraps
                w_events[EV_TICK] = 1'b1;
                if (r_emode == EM_TICK) begin
                    n_emode = EM_IDLE;
                end
                if (r_subtick != SUB_LAST) begin
                    n_subtick = r_subtick + 1'b1;
                end else begin
                    n_subtick = '0;
                    w_events[EV_20MS] = 1'b1;
                    if (r_emode == EM_20MS) begin
                        n_emode = EM_IDLE;
                    end
                    if (r_step != STEP_LAST) begin
                        n_step = r_step + 1'b1;
                    end else begin
                        n_step = '0;
                        w_events[EV_100MS] = 1'b1;
                        if (r_tenth != TENTH_LAST) begin
                            n_tenth = r_tenth + 1'b1;
                        end else begin
                            n_tenth = '0;
                            w_events[EV_SECOND] = 1'b1;
                            if (r_emode == EM_SECOND) begin
                                n_emode = EM_IDLE;
                            end
                            if (r_sec != SEC_LAST) begin
                                n_sec = r_sec + 1'b1;
                            end else begin
                                n_sec = '0;
                                w_events[EV_MINUTE] = 1'b1;
                                if (r_min != MIN_LAST) begin
                                    n_min = r_min + 1'b1;
                                end else begin
                                    n_min = '0;
                                    w_events[EV_HOUR] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            MODE_EDGE: begin
                if (r_emode == EM_NOTIFY) begin
                    w_ping = 1'b1;
                end else if (w_open_now) begin
                    n_total = r_total + 1'b1;
                end
            end
            MODE_SET_MIN: begin
                if (i_item.value < SET_LIMIT) begin
                    n_min = i_item.value[MIN_W-1:0];
                end
            end
            MODE_SET_SEC: begin
                if (i_item.value < SET_LIMIT) begin
                    n_sec = i_item.value[SEC_W-1:0];
                end
            end
            MODE_START: begin
                n_total = '0;
                case (i_item.window)
                    WIN_SECOND: n_emode = EM_SECOND;
                    WIN_TICK:   n_emode = EM_TICK;
                    WIN_20MS:   n_emode = EM_20MS;
                    default:    n_emode = EM_OPEN;
                endcase
            end
            MODE_NOTIFY: n_emode = EM_NOTIFY;
            MODE_STOP:   n_emode = EM_IDLE;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.events      = w_events;
        o_res.tenths      = n_tenth;
        o_res.seconds_now = n_sec;
        o_res.minutes_now = n_min;
        o_res.edge_count  = n_total;
        o_res.counting    = n_emode inside {EM_SECOND, EM_TICK, EM_20MS, EM_OPEN};
        o_res.ping        = w_ping;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subtick <= '0;
            r_step    <= '0;
            r_tenth   <= '0;
            r_sec     <= '0;
            r_min     <= '0;
            r_emode   <= EM_IDLE;
            r_total   <= '0;
        end else if (i_en) begin
            r_subtick <= n_subtick;
            r_step    <= n_step;
            r_tenth   <= n_tenth;
            r_sec     <= n_sec;
            r_min     <= n_min;
            r_emode   <= n_emode;
            r_total   <= n_total;
        end
    end

endmodule

// ===== rtl/tick_clock_with_gated_edge_counter.sv =====
// tick clock with a gated edge counter
// i_in carries one event per transfer: a tick, an external edge, a set of
// minutes or seconds (values of 60 or more are dropped), the start of an
// edge count with its window, notify mode, or stop. o_out returns exactly
// one result per input transfer: the boundaries a tick crossed, the time
// of day after the event, the edge total, whether a window is open and ping.
// a transfer lands in an input register; from there it is applied to the
// clock and counter state, and its result is written to the output register
// in the same cycle, once the output register is free.
// throughput: one item per cycle while the receiver takes each result, as
// the tick cascade and edge counter update combinationally.
// reset clears the time of day to zero, the edge total to zero and the
// counter to idle; both channel registers are emptied.
// when the receiver stalls, the held result stays on o_out, one further
// item waits in the input register and i_in.ready then drops until the
// output register is taken.
module tick_clock_with_gated_edge_counter #(
    parameter int unsigned TICKS_PER_STEP  = tcgec_pkg::TICKS_PER_STEP_DEF,
    parameter int unsigned STEPS_PER_TENTH = tcgec_pkg::STEPS_PER_TENTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcgec_in_if.sink    i_in,
    tcgec_out_if.source o_out
);
    import tcgec_pkg::*;

    logic    r_s1_vld;
    t_item   r_s1_item;
    logic    r_out_vld;
    t_result r_out;
    logic    w_out_free;
    logic    w_apply;
    t_item   w_in_item;
    t_result w_res;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_apply    = r_s1_vld && w_out_free;
    assign i_in.ready = !r_s1_vld || w_out_free;

    assign w_in_item.mode   = i_in.mode;
    assign w_in_item.value  = i_in.value;
    assign w_in_item.window = i_in.window;

    tcgec_core #(
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .STEPS_PER_TENTH(STEPS_PER_TENTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_apply),
        .i_item (r_s1_item),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item <= w_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.events      = r_out.events;
    assign o_out.tenths      = r_out.tenths;
    assign o_out.seconds_now = r_out.seconds_now;
    assign o_out.minutes_now = r_out.minutes_now;
    assign o_out.edge_count  = r_out.edge_count;
    assign o_out.counting    = r_out.counting;
    assign o_out.ping        = r_out.ping;

    // ping only comes from notify mode, which never has a window open
    a_ping_not_counting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.ping |-> !r_out.counting)
        else $error("ping reported with a count window open");

    // any boundary event is carried by a tick
    a_events_need_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.events != '0) |-> r_out.events[EV_TICK])
        else $error("boundary event without tick bit");

    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.seconds_now < SEC_W'(SECS_PER_MIN)) &&
                      (r_out.minutes_now < MIN_W'(MINS_PER_HOUR)) &&
                      (r_out.tenths < TENTHS_W'(TENTHS_PER_SEC)))
        else $error("time of day out of range");

    // input is only held off while both stages are full and the output stalls
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_vld && r_out_vld && !o_out.ready)
        else $error("input held off without a stall");

endmodule

// ===== tb/tb_tick_clock_with_gated_edge_counter.sv =====
module tb_tick_clock_with_gated_edge_counter;
    import tcgec_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 3'd7;
    localparam int unsigned TICKS_PER_STEP  = TICKS_PER_STEP_DEF;
    localparam int unsigned STEPS_PER_TENTH = STEPS_PER_TENTH_DEF;

    logic i_clk;
    logic i_rst_n;

    tcgec_in_if  in_if ();
    tcgec_out_if out_if ();

    tick_clock_with_gated_edge_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [VALUE_W-1:0]  value;
        logic [WINDOW_W-1:0] window;
        bit                  typed;
        t_result             readout;
    } t_dir_row;

    // readout fields: events, tenths, seconds, minutes, edge count, counting, ping
    t_dir_row dir_table [24] = '{
        '{MODE_NOP,     8'hFF, WIN_OPEN,   1'b1, {6'd0, 4'd0, 6'd0, 6'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_EDGE,    8'h00, WIN_SECOND, 1'b1, {6'd0, 4'd0, 6'd0, 6'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_SET_MIN, 8'd59, WIN_SECOND, 1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd0, 1'b0, 1'b0}},
        '{MODE_SET_MIN, 8'd60, WIN_TICK,   1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd0, 1'b0, 1'b0}},
        '{MODE_SET_MIN, 8'hFF, WIN_20MS,   1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd0, 1'b0, 1'b0}},
        '{MODE_SET_SEC, 8'd59, WIN_OPEN,   1'b1, {6'd0, 4'd0, 6'd59, 6'd59, 16'd0, 1'b0, 1'b0}},
        '{MODE_SET_SEC, 8'd60, WIN_SECOND, 1'b1, {6'd0, 4'd0, 6'd59, 6'd59, 16'd0, 1'b0, 1'b0}},
        '{MODE_SET_SEC, 8'd0,  WIN_SECOND, 1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd0, 1'b0, 1'b0}},
        '{MODE_START,   8'd0,  WIN_TICK,   1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd0, 1'b1, 1'b0}},
        '{MODE_EDGE,    8'd0,  WIN_SECOND, 1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd1, 1'b1, 1'b0}},
        '{MODE_EDGE,    8'd0,  WIN_SECOND, 1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd2, 1'b1, 1'b0}},
        '{MODE_TICK,    8'd0,  WIN_SECOND, 1'b1, {6'd1, 4'd0, 6'd0, 6'd59, 16'd2, 1'b0, 1'b0}},
        '{MODE_EDGE,    8'h80, WIN_TICK,   1'b0, '0},
        '{MODE_START,   8'hAA, WIN_OPEN,   1'b1, {6'd0, 4'd0, 6'd0, 6'd59, 16'd0, 1'b1, 1'b0}},
        '{MODE_TICK,    8'h55, WIN_20MS,   1'b0, '0},
        '{MODE_EDGE,    8'h01, WIN_TICK,   1'b0, '0},
        '{MODE_NOTIFY,  8'h7F, WIN_SECOND, 1'b0, '0},
        '{MODE_EDGE,    8'hFE, WIN_OPEN,   1'b0, '0},
        '{MODE_STOP,    8'h00, WIN_SECOND, 1'b0, '0},
        '{MODE_START,   8'h55, WIN_20MS,   1'b0, '0},
        '{MODE_EDGE,    8'h00, WIN_SECOND, 1'b0, '0},
        '{MODE_START,   8'h00, WIN_SECOND, 1'b0, '0},
        '{MODE_EDGE,    8'h3C, WIN_TICK,   1'b0, '0},
        '{MODE_NOTIFY,  8'hC3, WIN_OPEN,   1'b0, '0}
    };

    // time of day and edge counter as the block should hold them
    logic [4:0]         tod_subtick;
    logic [2:0]         tod_step;
    logic [TENTHS_W-1:0] tod_tenth;
    logic [SEC_W-1:0]   tod_sec;
    logic [MIN_W-1:0]   tod_min;
    t_edge_mode         cnt_mode;
    logic [COUNT_W-1:0] cnt_total;

    t_result expected_readouts [$];
    int      mismatches;
    int      src_idle_pct;
    int      sink_idle_pct;

    // set by the sender for the row on offer
    bit      row_typed;
    t_result row_readout;

    function automatic logic [EVENTS_W-1:0] advance_tick();
        logic [EVENTS_W-1:0] ev;
        ev = '0;
        ev[EV_TICK] = 1'b1;
        if (cnt_mode == EM_TICK) cnt_mode = EM_IDLE;
        tod_subtick = tod_subtick + 1'b1;
        if (tod_subtick == TICKS_PER_STEP) begin
            tod_subtick = '0;
            ev[EV_20MS] = 1'b1;
            if (cnt_mode == EM_20MS) cnt_mode = EM_IDLE;
            tod_step = tod_step + 1'b1;
            if (tod_step == STEPS_PER_TENTH) begin
                tod_step = '0;
                ev[EV_100MS] = 1'b1;
                tod_tenth = tod_tenth + 1'b1;
                if (tod_tenth == TENTHS_PER_SEC) begin
                    tod_tenth = '0;
                    ev[EV_SECOND] = 1'b1;
                    if (cnt_mode == EM_SECOND) cnt_mode = EM_IDLE;
                    tod_sec = tod_sec + 1'b1;
                    if (tod_sec == SECS_PER_MIN) begin
                        tod_sec = '0;
                        ev[EV_MINUTE] = 1'b1;
                        tod_min = tod_min + 1'b1;
                        if (tod_min == MINS_PER_HOUR) begin
                            tod_min = '0;
                            ev[EV_HOUR] = 1'b1;
                        end
                    end
                end
            end
        end
        return ev;
    endfunction

    function automatic t_result apply_event(input logic [MODE_W-1:0] mode,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [WINDOW_W-1:0] window);
        t_result r;
        logic    window_open;
        r = '0;
        window_open = cnt_mode inside {EM_SECOND, EM_TICK, EM_20MS, EM_OPEN};
        case (mode)
            MODE_TICK: r.events = advance_tick();
            MODE_EDGE: begin
                if (cnt_mode == EM_NOTIFY) r.ping = 1'b1;
                else if (window_open) cnt_total = cnt_total + 1'b1;
            end
            MODE_SET_MIN: if (value < SECS_PER_MIN) tod_min = value[MIN_W-1:0];
            MODE_SET_SEC: if (value < SECS_PER_MIN) tod_sec = value[SEC_W-1:0];
            MODE_START: begin
                cnt_total = '0;
                case (window)
                    WIN_SECOND: cnt_mode = EM_SECOND;
                    WIN_TICK:   cnt_mode = EM_TICK;
                    WIN_20MS:   cnt_mode = EM_20MS;
                    default:    cnt_mode = EM_OPEN;
                endcase
            end
            MODE_NOTIFY: cnt_mode = EM_NOTIFY;
            MODE_STOP:   cnt_mode = EM_IDLE;
            default: ;
        endcase
        r.tenths      = tod_tenth;
        r.seconds_now = tod_sec;
        r.minutes_now = tod_min;
        r.edge_count  = cnt_total;
        r.counting    = cnt_mode inside {EM_SECOND, EM_TICK, EM_20MS, EM_OPEN};
        return r;
    endfunction

    task automatic compare_readout(input t_result want, input t_result got);
        if (got.events !== want.events) begin
            $error("events: expected %0h, got %0h", want.events, got.events);
            mismatches++;
        end
        if (got.tenths !== want.tenths) begin
            $error("tenths: expected %0d, got %0d", want.tenths, got.tenths);
            mismatches++;
        end
        if (got.seconds_now !== want.seconds_now) begin
            $error("seconds_now: expected %0d, got %0d", want.seconds_now, got.seconds_now);
            mismatches++;
        end
        if (got.minutes_now !== want.minutes_now) begin
            $error("minutes_now: expected %0d, got %0d", want.minutes_now, got.minutes_now);
            mismatches++;
        end
        if (got.edge_count !== want.edge_count) begin
            $error("edge_count: expected %0d, got %0d", want.edge_count, got.edge_count);
            mismatches++;
        end
        if (got.counting !== want.counting) begin
            $error("counting: expected %0b, got %0b", want.counting, got.counting);
            mismatches++;
        end
        if (got.ping !== want.ping) begin
            $error("ping: expected %0b, got %0b", want.ping, got.ping);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // prediction on input transfers, checking on output transfers
    always @(posedge i_clk) begin
        t_result predicted;
        t_result got;
        if (!i_rst_n) begin
            tod_subtick <= '0;
            tod_step    <= '0;
            tod_tenth   <= '0;
            tod_sec     <= '0;
            tod_min     <= '0;
            cnt_mode    <= EM_IDLE;
            cnt_total   <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predicted = apply_event(in_if.mode, in_if.value, in_if.window);
                expected_readouts.push_back(row_typed ? row_readout : predicted);
            end
            if (out_if.valid && out_if.ready) begin
                got.events      = out_if.events;
                got.tenths      = out_if.tenths;
                got.seconds_now = out_if.seconds_now;
                got.minutes_now = out_if.minutes_now;
                got.edge_count  = out_if.edge_count;
                got.counting    = out_if.counting;
                got.ping        = out_if.ping;
                if (expected_readouts.size() == 0) begin
                    $error("readout with nothing expected");
                    mismatches++;
                end else begin
                    compare_readout(expected_readouts.pop_front(), got);
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs so the block backs up
    initial begin
        int hold;
        out_if.ready = 1'b0;
        wait (i_rst_n == 1'b1);
        hold = 80;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                if ($urandom_range(499) == 0) hold = $urandom_range(100, 30);
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                             input logic [WINDOW_W-1:0] window, input bit typed,
                             input t_result readout);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.mode   <= mode;
        in_if.value  <= value;
        in_if.window <= window;
        row_typed    = typed;
        row_readout  = readout;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [MODE_W-1:0] mode);
        send_item(mode, VALUE_W'($urandom), WINDOW_W'($urandom), 1'b0, '0);
    endtask

    task automatic drive_mixed(input int n_items);
        int sent;
        int len;
        logic [VALUE_W-1:0] v;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    // a count window with edges and ticks inside it
                    send_op(MODE_START);
                    len = $urandom_range(40, 1);
                    repeat (len) send_op(($urandom_range(9) < 7) ? MODE_EDGE : MODE_TICK);
                    if ($urandom_range(2) == 0) send_op(MODE_STOP);
                    sent += len + 2;
                end
                4: begin
                    send_op(MODE_NOTIFY);
                    len = $urandom_range(10, 1);
                    repeat (len) send_op(($urandom_range(3) != 0) ? MODE_EDGE : MODE_TICK);
                    send_op(($urandom_range(1) != 0) ? MODE_STOP : MODE_START);
                    sent += len + 2;
                end
                5, 6: begin
                    len = $urandom_range(150, 1);
                    repeat (len) send_op(MODE_TICK);
                    sent += len;
                end
                7: begin
                    case ($urandom_range(3))
                        0, 1:    v = VALUE_W'($urandom_range(59));
                        2:       v = VALUE_W'($urandom_range(63, 56));
                        default: v = VALUE_W'($urandom_range(255));
                    endcase
                    send_item(($urandom_range(1) != 0) ? MODE_SET_MIN : MODE_SET_SEC, v,
                              WINDOW_W'($urandom), 1'b0, '0);
                    sent += 1;
                end
                default: begin
                    len = $urandom_range(5, 1);
                    repeat (len) send_op(MODE_W'($urandom_range(7)));
                    sent += len;
                end
            endcase
        end
    endtask

    initial begin
        mismatches    = 0;
        src_idle_pct  = 16;
        sink_idle_pct = 60;
        row_typed     = 1'b0;
        row_readout   = '0;
        in_if.valid   = 1'b0;
        in_if.mode    = MODE_TICK;
        in_if.value   = '0;
        in_if.window  = '0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[k])
            send_item(dir_table[k].mode, dir_table[k].value, dir_table[k].window,
                      dir_table[k].typed, dir_table[k].readout);

        drive_mixed(180);
        src_idle_pct  = 60;
        sink_idle_pct = 16;
        drive_mixed(180);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        drive_mixed(180);

        // last second of the hour with a one-second window open
        send_item(MODE_SET_MIN, 8'd59, WINDOW_W'($urandom), 1'b0, '0);
        send_item(MODE_SET_SEC, 8'd59, WINDOW_W'($urandom), 1'b0, '0);
        send_item(MODE_START, VALUE_W'($urandom), WIN_SECOND, 1'b0, '0);
        repeat (3) send_op(MODE_EDGE);
        repeat (30) send_op(MODE_TICK);
        send_op(MODE_STOP);

        in_if.valid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
